// ===== rtl/gdw_pkg.sv =====
// gdw_pkg: shared types, codes and helpers for the grid depth-first walker
// used by gdw_ctrl, gdw_datapath and grid_dfs_walker; depends on nothing else
package gdw_pkg;

  // step kinds carried in the mode field
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_PLACE   = 2'd1;
  localparam logic [1:0] MODE_EXPLORE = 2'd2;
  localparam logic [1:0] MODE_BACK    = 2'd3;

  // cell kinds, bits 1:0 of a cell
  localparam logic [1:0] KIND_FREE    = 2'd0;
  localparam logic [1:0] KIND_GOAL    = 2'd1;
  localparam logic [1:0] KIND_VISITED = 2'd2;
  localparam logic [1:0] KIND_BLOCKED = 2'd3;

  // directions, bits 3:2 of a cell and the move code
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;
  localparam logic [2:0] NO_MOVE   = 3'd4;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int CELL_W  = 4;
  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;
  localparam int COUNT_W = 16;

  // position with one spare bit, so a step off either edge lands past the grid
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } gdw_pos_t;

  // commands from the controller
  typedef struct packed {
    logic take_in;
    logic dir_inc;
    logic do_load;
    logic do_place;
    logic do_enter;
    logic do_stay;
    logic do_back;
    logic cnt_inc;
    logic set_err;
    logic do_out;
  } gdw_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       cur_on_grid;
    logic       probe_on_grid;
    logic       probe_last;
    logic       enterable;
    logic       out_busy;
  } gdw_status_t;

  // one step in a direction; up from row 0 or left from column 0 wraps to 127
  function automatic gdw_pos_t step_pos(input logic [DIM_W-1:0] row,
                                        input logic [DIM_W-1:0] col,
                                        input logic [1:0] dir);
    gdw_pos_t p;
    p.row = row;
    p.col = col;
    case (dir)
      DIR_UP:    p.row = row - 7'd1;
      DIR_RIGHT: p.col = col + 7'd1;
      DIR_DOWN:  p.row = row + 7'd1;
      default:   p.col = col - 7'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/gdw_ram.sv =====
// gdw_ram: generic single-port RAM with registered read
// no dependencies
module gdw_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read first port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/gdw_ctrl.sv =====
// gdw_ctrl: step sequencer for the grid walker
// depends on gdw_pkg; drives gdw_datapath through gdw_cmd_t
module gdw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gdw_pkg::gdw_status_t st,
  output gdw_pkg::gdw_cmd_t   cmd
);
  import gdw_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_PROBE    = 3'd2;
  localparam logic [2:0] S_EWAIT    = 3'd3;
  localparam logic [2:0] S_BWAIT    = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.mode)
          MODE_LOAD: begin
            cmd.do_load = 1'b1;
            state_next  = S_FINISH;
          end
          MODE_PLACE: begin
            cmd.do_place = 1'b1;
            state_next   = S_FINISH;
          end
          MODE_EXPLORE: begin
            cmd.cnt_inc = 1'b1;
            state_next  = st.cur_on_grid ? S_PROBE : S_FINISH;
          end
          default: begin
            // current cell read is under way when on the grid
            if (st.cur_on_grid) begin
              state_next = S_BWAIT;
            end else begin
              cmd.set_err = 1'b1;
              state_next  = S_FINISH;
            end
          end
        endcase
      end
      S_PROBE: begin
        if (st.probe_on_grid) begin
          state_next = S_EWAIT;
        end else begin
          cmd.dir_inc = 1'b1;
        end
      end
      S_EWAIT: begin
        if (st.probe_last) begin
          cmd.do_stay = 1'b1;
          state_next  = S_FINISH;
        end else if (st.enterable) begin
          cmd.do_enter = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.dir_inc = 1'b1;
          state_next  = S_PROBE;
        end
      end
      S_BWAIT: begin
        cmd.do_back = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.do_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/gdw_datapath.sv =====
// gdw_datapath: grid store, cursor, flags, counters and output register
// depends on gdw_pkg and gdw_ram; commanded by gdw_ctrl
module gdw_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic [15:0]          in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [39:0]          out_data,
  input  gdw_pkg::gdw_cmd_t    cmd,
  output gdw_pkg::gdw_status_t st
);
  import gdw_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LIM_R = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam int LIM_C = (MAX_COLS < 64) ? MAX_COLS : 64;

  logic [DIM_W-1:0]   grid_rows;
  logic [DIM_W-1:0]   grid_cols;
  logic [DIM_W-1:0]   eff_rows;
  logic [DIM_W-1:0]   eff_cols;
  logic [1:0]         item_mode;
  logic [COORD_W-1:0] item_x;
  logic [COORD_W-1:0] item_y;
  logic [1:0]         item_kind;
  logic [COORD_W-1:0] cursor_col;
  logic [COORD_W-1:0] cursor_row;
  logic               goal_flag;
  logic [COUNT_W-1:0] step_count;
  logic [2:0]         dir_idx;
  logic [2:0]         code_r;
  logic               err_r;
  gdw_pos_t           cur_pos;
  gdw_pos_t           probe_pos;
  gdw_pos_t           item_pos;
  gdw_pos_t           back_pos;
  gdw_pos_t           sel_pos;
  logic               item_on_grid;
  logic               back_on_grid;
  logic               rd_goal;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]  ram_rdata;

  function automatic logic on_grid(input gdw_pos_t p, input logic [DIM_W-1:0] rows,
                                   input logic [DIM_W-1:0] cols);
    return (p.row < rows) && (p.col < cols);
  endfunction

  // effective grid size
  assign eff_rows = (grid_rows > DIM_W'(LIM_R)) ? DIM_W'(LIM_R) : grid_rows;
  assign eff_cols = (grid_cols > DIM_W'(LIM_C)) ? DIM_W'(LIM_C) : grid_cols;

  // positions under test
  assign cur_pos.row  = {1'b0, cursor_row};
  assign cur_pos.col  = {1'b0, cursor_col};
  assign item_pos.row = {1'b0, item_y};
  assign item_pos.col = {1'b0, item_x};
  assign probe_pos    = dir_idx[2] ? cur_pos
                                   : step_pos(cur_pos.row, cur_pos.col, dir_idx[1:0]);
  assign back_pos     = step_pos(cur_pos.row, cur_pos.col, ram_rdata[3:2]);
  assign item_on_grid = on_grid(item_pos, eff_rows, eff_cols);
  assign back_on_grid = on_grid(back_pos, eff_rows, eff_cols);
  assign rd_goal      = (ram_rdata[1:0] == KIND_GOAL);

  // status to the controller
  assign st.mode          = item_mode;
  assign st.cur_on_grid   = on_grid(cur_pos, eff_rows, eff_cols);
  assign st.probe_on_grid = on_grid(probe_pos, eff_rows, eff_cols);
  assign st.probe_last    = dir_idx[2];
  assign st.enterable     = (ram_rdata[1:0] == KIND_FREE) || rd_goal;
  assign st.out_busy      = out_valid && !out_ready;

  // cell address: load uses the item position, everything else the probe
  assign sel_pos  = (item_mode == MODE_LOAD) ? item_pos : probe_pos;
  assign ram_addr = AW'(AW'(sel_pos.row[COORD_W-1:0]) * AW'(MAX_COLS))
                  + AW'(sel_pos.col[COORD_W-1:0]);

  // cell write port
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {DIR_UP, item_kind};
    if (cmd.do_load) begin
      ram_we    = item_on_grid;
      ram_wdata = {DIR_UP, item_kind};
    end else if (cmd.do_enter) begin
      ram_we    = 1'b1;
      ram_wdata = {dir_idx[1:0] ^ 2'd2, rd_goal ? KIND_GOAL : KIND_VISITED};
    end else if (cmd.do_stay) begin
      ram_we    = !rd_goal;
      ram_wdata = {ram_rdata[3:2], KIND_VISITED};
    end
  end

  gdw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(DEPTH)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        grid_rows <= cfg_data;
      end else begin
        grid_cols <= cfg_data;
      end
    end
  end

  // item capture and probe direction
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      item_mode <= in_data[1:0];
      item_x    <= in_data[7:2];
      item_y    <= in_data[13:8];
      item_kind <= in_data[15:14];
      dir_idx   <= (in_data[1:0] == MODE_EXPLORE) ? 3'd0 : 3'd4;
    end else if (cmd.dir_inc) begin
      dir_idx <= dir_idx + 3'd1;
    end
  end

  // per-item result code and error
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      code_r <= NO_MOVE;
      err_r  <= 1'b0;
    end else begin
      if (cmd.do_enter) begin
        code_r <= {1'b0, dir_idx[1:0]};
      end
      if (cmd.set_err || ((cmd.do_load || cmd.do_place) && !item_on_grid)
          || (cmd.do_back && !back_on_grid)) begin
        err_r <= 1'b1;
      end
    end
  end

  // cursor, goal flag and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
      goal_flag  <= 1'b0;
      step_count <= '0;
    end else begin
      if (cmd.do_place && item_on_grid) begin
        cursor_col <= item_x;
        cursor_row <= item_y;
        goal_flag  <= 1'b0;
      end
      if (cmd.do_enter) begin
        cursor_col <= probe_pos.col[COORD_W-1:0];
        cursor_row <= probe_pos.row[COORD_W-1:0];
      end
      if (cmd.do_back && back_on_grid) begin
        cursor_col <= back_pos.col[COORD_W-1:0];
        cursor_row <= back_pos.row[COORD_W-1:0];
      end
      if ((cmd.do_enter || cmd.do_stay) && rd_goal) begin
        goal_flag <= 1'b1;
      end
      if (cmd.cnt_inc && (step_count != '1)) begin
        step_count <= step_count + 16'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.do_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_out) begin
      out_data <= {7'd0, err_r, step_count, goal_flag, cursor_row, cursor_col, code_r};
    end
  end

endmodule

// ===== rtl/grid_dfs_walker.sv =====
// grid_dfs_walker: top level of the depth-first grid walker
// depends on gdw_pkg, gdw_ctrl, gdw_datapath and gdw_ram
//
// Usage: each transfer on the s_axis channel is one step (load a cell, place
// the cursor, explore or backtrack); each step gives exactly one transfer on
// the m_axis channel with the move code, cursor, goal flag, explore count and
// range error after the step. The cfg port writes grid_rows (index 0) and
// grid_cols (index 1); write it only while no step is in flight.
// Explore reads the neighbor cells in turn and skips each neighbor that is off
// the grid (the cursor cell itself is read last when no neighbor can be
// entered); backtrack reads the cursor cell; with the cursor off the grid
// neither reads a cell. Cell reads go through the single port of the cell
// RAM, whose read data is registered. One step at a time; the next
// step is taken as soon as the sequencer is back to idle, while the last
// result may still sit in the output register. If the receiver stalls, the
// result holds and the walker stops before its next output until it is taken.
// Reset clears cursor, goal flag, count and grid size (64 x 64); cell
// contents are not cleared and must be loaded before they are read.
module grid_dfs_walker #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // mode[1:0], col_x[7:2], row_y[13:8], cell_kind[15:14]
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // move_code[2:0], cursor_x[8:3], cursor_y[14:9], goal_reached[15],
  // explore_count[31:16], range_error[32], zero fill[39:33]
  output logic [39:0] m_axis_tdata
);
  import gdw_pkg::*;

  gdw_cmd_t    cmd;
  gdw_status_t st;

  gdw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  gdw_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_axis_tdata),
    .out_ready(m_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_data (m_axis_tdata),
    .cmd      (cmd),
    .st       (st)
  );

endmodule

// ===== test/grid_dfs_walker_test.sv =====
`timescale 1ns / 100ps
// grid_dfs_walker_test: self-checking bench for the depth-first grid walker
// steps go in on s_axis; each m_axis transfer is checked against a local walk predictor
// or a fixed expected result; depends on gdw_pkg and grid_dfs_walker
module grid_dfs_walker_test;
  import gdw_pkg::*;

  localparam int GRID_SIDE    = 64;
  localparam int CYCLE_LIMIT  = 4000000;
  localparam int RANDOM_STEPS = 1750;
  localparam int MAX_PRINTED  = 50;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] kind;
  } step_t;

  typedef struct packed {
    logic [2:0]  move;
    logic [5:0]  cur_x;
    logic [5:0]  cur_y;
    logic        goal;
    logic [15:0] count;
    logic        err;
  } walk_result_t;

  typedef struct packed {
    logic         is_cfg;
    logic         reg_sel;
    logic [6:0]   reg_val;
    step_t        step;
    logic         typed;
    walk_result_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = 7'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // mode[1:0], col_x[7:2], row_y[13:8], cell_kind[15:14]
  logic [15:0] s_axis_tdata = 16'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // move_code[2:0], cursor_x[8:3], cursor_y[14:9], goal_reached[15],
  // explore_count[31:16], range_error[32], zero fill[39:33]
  logic [39:0] m_axis_tdata;

  // local copy of the walker state
  logic [3:0]  maze [0:GRID_SIDE*GRID_SIDE-1];
  bit          loaded [0:GRID_SIDE*GRID_SIDE-1];
  int          pos_col = 0;
  int          pos_row = 0;
  logic        goal_seen = 1'b0;
  logic [15:0] explore_steps = 16'd0;
  logic [6:0]  rows_reg = 7'd64;
  logic [6:0]  cols_reg = 7'd64;

  walk_result_t  pending_results [$];
  directed_row_t plan [$];
  int            steps_sent = 0;
  int            results_seen = 0;
  int            mismatches = 0;
  int            cycles = 0;
  int            src_idle_pct = 0;
  int            sink_stall_pct = 0;

  grid_dfs_walker uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic int used_rows();
    return (rows_reg > 7'd64) ? 64 : int'(rows_reg);
  endfunction

  function automatic int used_cols();
    return (cols_reg > 7'd64) ? 64 : int'(cols_reg);
  endfunction

  function automatic bit inside_grid(int r, int c);
    return r >= 0 && c >= 0 && r < used_rows() && c < used_cols();
  endfunction

  function automatic int slot(int r, int c);
    return r * GRID_SIDE + c;
  endfunction

  function automatic bit open_cell(int r, int c);
    if (!inside_grid(r, c)) return 1'b0;
    return maze[slot(r, c)][1:0] == KIND_FREE || maze[slot(r, c)][1:0] == KIND_GOAL;
  endfunction

  // one walker step on the local copy, gives the transfer the block should send
  function automatic walk_result_t predict_walk(step_t s);
    walk_result_t res;
    int r, c, tr, tc, lr, lc;
    logic [1:0] home;
    r = pos_row;
    c = pos_col;
    lr = int'(s.row);
    lc = int'(s.col);
    home = DIR_UP;
    res = '0;
    res.move = NO_MOVE;
    case (s.mode)
      MODE_LOAD: begin
        if (inside_grid(lr, lc)) begin
          maze[slot(lr, lc)] = {DIR_UP, s.kind};
          loaded[slot(lr, lc)] = 1'b1;
        end else begin
          res.err = 1'b1;
        end
      end
      MODE_PLACE: begin
        if (inside_grid(lr, lc)) begin
          pos_col = lc;
          pos_row = lr;
          goal_seen = 1'b0;
        end else begin
          res.err = 1'b1;
        end
      end
      MODE_EXPLORE: begin
        if (explore_steps != 16'hFFFF) explore_steps = explore_steps + 16'd1;
        // cursor past the edge: no move and nothing written
        if (inside_grid(r, c)) begin
          if (open_cell(r - 1, c)) begin
            r = r - 1;
            res.move = {1'b0, DIR_UP};
            home = DIR_DOWN;
          end else if (open_cell(r, c + 1)) begin
            c = c + 1;
            res.move = {1'b0, DIR_RIGHT};
            home = DIR_LEFT;
          end else if (open_cell(r + 1, c)) begin
            r = r + 1;
            res.move = {1'b0, DIR_DOWN};
            home = DIR_UP;
          end else if (open_cell(r, c - 1)) begin
            c = c - 1;
            res.move = {1'b0, DIR_LEFT};
            home = DIR_RIGHT;
          end
          if (res.move != NO_MOVE) maze[slot(r, c)][3:2] = home;
          pos_row = r;
          pos_col = c;
          if (maze[slot(r, c)][1:0] == KIND_GOAL) begin
            goal_seen = 1'b1;
          end else begin
            maze[slot(r, c)][1:0] = KIND_VISITED;
          end
        end
      end
      MODE_BACK: begin
        if (!inside_grid(r, c)) begin
          res.err = 1'b1;
        end else begin
          tr = r;
          tc = c;
          // a cell never entered keeps the home direction up from its load
          case (maze[slot(r, c)][3:2])
            DIR_DOWN:  tr = r + 1;
            DIR_LEFT:  tc = c - 1;
            DIR_RIGHT: tc = c + 1;
            default:   tr = r - 1;
          endcase
          if (inside_grid(tr, tc)) begin
            pos_row = tr;
            pos_col = tc;
          end else begin
            res.err = 1'b1;
          end
        end
      end
    endcase
    res.cur_x = pos_col[5:0];
    res.cur_y = pos_row[5:0];
    res.goal  = goal_seen;
    res.count = explore_steps;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [39:0] got,
                                 input logic [39:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // compare one output transfer with the oldest expectation
  task automatic check_result(input logic [39:0] bus);
    walk_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("transfer with nothing pending", bus, 40'd0);
    end else begin
      want = pending_results.pop_front();
      if (bus[2:0] !== want.move)
        report_mismatch("move_code", 40'(bus[2:0]), 40'(want.move));
      if (bus[8:3] !== want.cur_x)
        report_mismatch("cursor_x", 40'(bus[8:3]), 40'(want.cur_x));
      if (bus[14:9] !== want.cur_y)
        report_mismatch("cursor_y", 40'(bus[14:9]), 40'(want.cur_y));
      if (bus[15] !== want.goal)
        report_mismatch("goal_reached", 40'(bus[15]), 40'(want.goal));
      if (bus[31:16] !== want.count)
        report_mismatch("explore_count", 40'(bus[31:16]), 40'(want.count));
      if (bus[32] !== want.err)
        report_mismatch("range_error", 40'(bus[32]), 40'(want.err));
      if (bus[39:33] !== 7'd0)
        report_mismatch("zero fill", 40'(bus[39:33]), 40'd0);
    end
  endtask

  // output side: random stall and transfer check
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  task automatic set_idling(input idle_mode_t m);
    case (m)
      IDLE_SENDER:   begin src_idle_pct = 52; sink_stall_pct = 0; end
      IDLE_RECEIVER: begin src_idle_pct = 0; sink_stall_pct = 52; end
      IDLE_BOTH:     begin src_idle_pct = 35; sink_stall_pct = 35; end
      default:       begin src_idle_pct = 0; sink_stall_pct = 0; end
    endcase
  endtask

  // input transfer, then the expectation it causes
  task automatic send_step(input step_t s, input logic typed, input walk_result_t want,
                           output walk_result_t res);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {s.kind, s.row, s.col, s.mode};
    do @(posedge clk); while (!s_axis_tready);
    res = predict_walk(s);
    pending_results.push_back(typed ? want : res);
    steps_sent++;
  endtask

  task automatic do_step(input logic [1:0] mode, input logic [5:0] col, input logic [5:0] row,
                         input logic [1:0] kind, output walk_result_t res);
    step_t s;
    s.mode = mode;
    s.col  = col;
    s.row  = row;
    s.kind = kind;
    send_step(s, 1'b0, '0, res);
  endtask

  // hold the sender off until every expected transfer is in
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [6:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (sel == REG_ROWS) rows_reg = val;
    else cols_reg = val;
  endtask

  function automatic logic [1:0] rand_kind();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return KIND_FREE;
    if (p < 58) return KIND_GOAL;
    if (p < 75) return KIND_VISITED;
    return KIND_BLOCKED;
  endfunction

  // any coordinate or kind field value
  function automatic logic [5:0] rand_coord();
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [1:0] rand_field_kind();
    return 2'($urandom_range(0, 3));
  endfunction

  // mostly small grids, sometimes the extremes or anything in range
  task automatic pick_grid();
    logic [6:0] nr, nc;
    nr = 7'($urandom_range(1, 12));
    nc = 7'($urandom_range(1, 12));
    case ($urandom_range(0, 7))
      0: nr = 7'd1;
      1: nc = 7'd1;
      2: begin nr = 7'd64; nc = 7'd64; end
      3: begin nr = 7'($urandom_range(1, 64)); nc = 7'($urandom_range(1, 64)); end
      default: begin end
    endcase
    write_reg(REG_ROWS, nr);
    write_reg(REG_COLS, nc);
  endtask

  task automatic place_on_grid();
    walk_result_t res;
    do_step(MODE_PLACE, 6'($urandom_range(0, used_cols() - 1)),
            6'($urandom_range(0, used_rows() - 1)), rand_field_kind(), res);
  endtask

  // load the cursor cell and its in-grid neighbors that were never written
  task automatic fill_around();
    walk_result_t res;
    int k, r, c;
    for (k = 0; k < 5; k++) begin
      r = pos_row;
      c = pos_col;
      case (k)
        1: r = r - 1;
        2: c = c + 1;
        3: r = r + 1;
        4: c = c - 1;
        default: begin end
      endcase
      if (inside_grid(r, c) && !loaded[slot(r, c)])
        do_step(MODE_LOAD, 6'(c), 6'(r), rand_kind(), res);
    end
  endtask

  // fresh maze on small grids, then a cursor on the grid
  task automatic start_maze();
    walk_result_t res;
    int r, c;
    if (used_rows() * used_cols() <= 48) begin
      for (r = 0; r < used_rows(); r++)
        for (c = 0; c < used_cols(); c++)
          do_step(MODE_LOAD, 6'(c), 6'(r), rand_kind(), res);
    end
    if ($urandom_range(0, 9) == 0)
      do_step(MODE_PLACE, rand_coord(), rand_coord(), rand_field_kind(), res);
    place_on_grid();
  endtask

  // depth-first walk: explore until stuck, then mostly backtrack, with some noise
  task automatic walk_maze(input int n);
    walk_result_t res;
    logic stuck;
    int i, pick;
    stuck = 1'b0;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) drain();
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        do_step(MODE_LOAD, rand_coord(), rand_coord(), rand_field_kind(), res);
      end else if (pick < 6) begin
        do_step(MODE_PLACE, rand_coord(), rand_coord(), rand_field_kind(), res);
      end else if (pick < 8) begin
        pick_grid();
      end else if (!inside_grid(pos_row, pos_col) &&
                   (!loaded[slot(pos_row, pos_col)] || $urandom_range(0, 1))) begin
        place_on_grid();
      end else begin
        fill_around();
        if (stuck ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 20)) begin
          do_step(MODE_BACK, rand_coord(), rand_coord(), rand_field_kind(), res);
          stuck = 1'b0;
        end else begin
          do_step(MODE_EXPLORE, rand_coord(), rand_coord(), rand_field_kind(), res);
          stuck = (res.move == NO_MOVE);
        end
      end
    end
  endtask

  function automatic directed_row_t cfg_row(input logic sel, input logic [6:0] val);
    directed_row_t d;
    d = '0;
    d.is_cfg  = 1'b1;
    d.reg_sel = sel;
    d.reg_val = val;
    return d;
  endfunction

  function automatic directed_row_t step_row(input logic [1:0] mode, input logic [5:0] col,
                                             input logic [5:0] row, input logic [1:0] kind);
    directed_row_t d;
    d = '0;
    d.step.mode = mode;
    d.step.col  = col;
    d.step.row  = row;
    d.step.kind = kind;
    return d;
  endfunction

  // row whose result is plain to see: no move, known cursor and flags
  function automatic directed_row_t known_row(input directed_row_t d, input logic [5:0] cx,
                                              input logic [5:0] cy, input logic goal,
                                              input logic [15:0] count, input logic err);
    d.typed      = 1'b1;
    d.want.move  = NO_MOVE;
    d.want.cur_x = cx;
    d.want.cur_y = cy;
    d.want.goal  = goal;
    d.want.count = count;
    d.want.err   = err;
    return d;
  endfunction

  initial begin
    walk_result_t res;
    step_t s;
    int stop_at, episode;

    // directed steps, starting on the 64 x 64 grid with the cursor at the origin
    plan.push_back(known_row(step_row(MODE_LOAD, 0, 0, KIND_FREE), 0, 0, 0, 0, 0));
    plan.push_back(known_row(step_row(MODE_LOAD, 63, 63, KIND_BLOCKED), 0, 0, 0, 0, 0));
    plan.push_back(step_row(MODE_LOAD, 1, 0, KIND_GOAL));
    plan.push_back(step_row(MODE_LOAD, 0, 1, KIND_VISITED));
    plan.push_back(step_row(MODE_EXPLORE, 0, 0, 0));
    plan.push_back(step_row(MODE_BACK, 0, 0, 0));
    // origin was never entered: home is up, off the top edge
    plan.push_back(known_row(step_row(MODE_BACK, 63, 63, 3), 0, 0, 1, 1, 1));
    plan.push_back(cfg_row(REG_ROWS, 7'd1));
    plan.push_back(cfg_row(REG_COLS, 7'd1));
    plan.push_back(known_row(step_row(MODE_LOAD, 5, 0, KIND_GOAL), 0, 0, 1, 1, 1));
    plan.push_back(known_row(step_row(MODE_PLACE, 0, 5, 0), 0, 0, 1, 1, 1));
    plan.push_back(step_row(MODE_EXPLORE, 0, 0, 0));
    plan.push_back(known_row(step_row(MODE_PLACE, 0, 0, 0), 0, 0, 0, 2, 0));
    plan.push_back(cfg_row(REG_ROWS, 7'd64));
    plan.push_back(cfg_row(REG_COLS, 7'd64));
    // far corner: explore can only go left, then walk back out of it
    plan.push_back(step_row(MODE_LOAD, 63, 62, KIND_VISITED));
    plan.push_back(step_row(MODE_LOAD, 62, 63, KIND_FREE));
    plan.push_back(step_row(MODE_PLACE, 63, 63, 0));
    plan.push_back(step_row(MODE_EXPLORE, 63, 63, 3));
    plan.push_back(step_row(MODE_BACK, 0, 0, 0));
    plan.push_back(step_row(MODE_BACK, 0, 0, 0));
    plan.push_back(step_row(MODE_BACK, 0, 0, 0));
    // shrink under the cursor
    plan.push_back(cfg_row(REG_COLS, 7'd10));
    plan.push_back(step_row(MODE_BACK, 0, 0, 0));
    plan.push_back(step_row(MODE_EXPLORE, 0, 0, 0));
    plan.push_back(step_row(MODE_LOAD, 63, 61, KIND_FREE));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_idling(IDLE_NONE);
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].reg_sel, plan[i].reg_val);
      else send_step(plan[i].step, plan[i].typed, plan[i].want, res);
    end

    // random walks over random mazes, idling phase rotating per maze
    stop_at = steps_sent + RANDOM_STEPS;
    episode = 0;
    while (steps_sent < stop_at) begin
      set_idling(idle_mode_t'(episode % 4));
      if ($urandom_range(0, 1)) pick_grid();
      start_maze();
      walk_maze($urandom_range(20, 60));
      episode++;
    end

    // a few explore steps back to back with the cursor past the right edge
    set_idling(IDLE_NONE);
    write_reg(REG_ROWS, 7'd64);
    write_reg(REG_COLS, 7'd64);
    do_step(MODE_LOAD, 40, 40, KIND_FREE, res);
    do_step(MODE_PLACE, 40, 40, 0, res);
    write_reg(REG_COLS, 7'd20);
    s.mode = MODE_EXPLORE;
    s.col  = 6'd0;
    s.row  = 6'd0;
    s.kind = 2'd0;
    repeat (3) send_step(s, 1'b0, '0, res);

    drain();
    repeat (30) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never arrived", 40'(pending_results.size()), 40'd0);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
